[rtl/srbc_pkg.sv]
// Shared types and constants for the sprite row / background combiner.
package srbc_pkg;

    localparam int SPRITE_ROWS     = 16;
    localparam int SPRITE_Y_OFFSET = 17;
    localparam int LINE_MIN_OFFSET = 16;
    localparam int ROW_PIXELS      = 8;

    localparam logic [1:0] OP_BG_WRITE  = 2'd0;
    localparam logic [1:0] OP_GFX_WRITE = 2'd1;
    localparam logic [1:0] OP_DRAW_ROW  = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    localparam logic [1:0] REG_PALETTE_BANK = 2'd0;
    localparam logic [1:0] REG_SPRITE_BANK  = 2'd1;
    localparam logic [1:0] REG_CLIP_MIN_Y   = 2'd2;
    localparam logic [1:0] REG_CLIP_MAX_Y   = 2'd3;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WR_BG,
        ST_WR_GFX,
        ST_Y0,
        ST_Y1,
        ST_CK_VB,
        ST_CK_MIN,
        ST_CK_MAX,
        ST_B_IMG,
        ST_B_BANK,
        ST_B_ROW,
        ST_B_MOD,
        ST_BG_BASE,
        ST_P_GA,
        ST_P_GM,
        ST_P_BA,
        ST_P_EMIT,
        ST_FLUSH
    } state_t;

endpackage

[rtl/srbc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module srbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/srbc_alu.sv]
// Shared add / subtract unit with borrow flag.
module srbc_alu
    import srbc_pkg::*;
#(
    parameter int W = 19
) (
    input  alu_op_t      op,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] res,
    output logic         borrow
);

    logic [W:0] sum;

    always_comb begin
        if (op == ALU_SUB) begin
            sum = {1'b0, a} + {1'b0, ~b} + {{W{1'b0}}, 1'b1};
        end else begin
            sum = {1'b0, a} + {1'b0, b};
        end
        res    = sum[W-1:0];
        borrow = (op == ALU_SUB) && !sum[W];
    end

endmodule

[rtl/sprite_row_background_combine.sv]
// Top level of the sprite row / background combiner.
//
// Items enter on the s_ stream; s_tuser carries the opcode. A video byte write
// (two background nibbles) or a graphics byte write is done in its own write
// state. A draw item runs a sequencer over one shared add/subtract unit: setup
// (line, line checks, graphics base, address reduction by repeated subtraction,
// background base), then per pixel the graphics address add, wrap, RAM read and
// merge for the 8 pixels, and a last step to release the held pixel; a row that
// fails the line checks returns the block to idle at the failing check.
// s_tready is high only while the sequencer is idle.
// Each non-transparent, on-screen pixel leaves on the m_ stream; m_tlast marks
// the final pixel of a row. A row that is clipped or fully transparent gives no
// items. One pixel is held back so tlast can be set; it leaves when the next one
// is found or when the row ends.
// The output register parts the two sides: a stalled receiver holds the current
// item and blocks the sequencer only when a further pixel must move out.
// Registers are to be written over the APB port while the block is idle; the
// block does not enforce it. Reset clears the sequencer, the output stream and
// the registers; the background and graphics memories are not cleared.
module sprite_row_background_combine
    import srbc_pkg::*;
#(
    parameter int VBLANK_END     = 16,
    parameter int GRAPHICS_BYTES = 131072,
    parameter int BANK_OFFSET    = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[16:0], data[24:17], sprite_flags[32:25], sprite_image[40:33],
    // sprite_y[48:41], sprite_x[56:49], row[60:57], zero[63:61]
    input  logic [63:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_x[7:0], pixel_y[16:8], pen[26:17], zero[31:27]
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ALU_W  = $clog2(BANK_OFFSET + 2 * GRAPHICS_BYTES + 64);
    localparam int GFX_AW = $clog2(GRAPHICS_BYTES);
    localparam int BG_AW  = 15;

    state_t state_reg, state_next;

    logic [1:0]  palette_bank_reg;
    logic        sprite_bank_reg;
    logic [8:0]  clip_min_reg;
    logic [8:0]  clip_max_reg;

    logic [16:0] addr_reg;
    logic [7:0]  data_reg, flags_reg, image_reg, sy_reg, sx_reg;
    logic [3:0]  row_reg;

    logic [8:0]        y_reg, y_next;
    logic [ALU_W-1:0]  acc_reg, acc_next;
    logic [15:0]       bgb_reg, bgb_next;
    logic [ALU_W-1:0]  ga_reg, ga_next;
    logic [GFX_AW-1:0] gaddr_reg, gaddr_next;
    logic [2:0]        pix_reg, pix_next;
    logic              bgsel_reg, bgsel_next;

    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_x_reg, pend_x_next;
    logic [8:0]  pend_y_reg, pend_y_next;
    logic [9:0]  pend_pen_reg, pend_pen_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_x_reg, out_x_next;
    logic [8:0]  out_y_reg, out_y_next;
    logic [9:0]  out_pen_reg, out_pen_next;
    logic        out_last_reg, out_last_next;

    alu_op_t          alu_op;
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_borrow;

    logic              gfx_we, gfx_re;
    logic [GFX_AW-1:0] gfx_waddr;
    logic [7:0]        gfx_rdata;
    logic              bg_we, bg_re;
    logic [BG_AW-1:0]  bg_raddr;
    logic [7:0]        bg_rdata;

    logic       s_accept, cfg_we, out_free;
    logic [1:0] kk;
    logic [3:0] row_eff, nib, bg_nib;
    logic [8:0] col;
    logic       nib_hi, emit, emit_stall;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_pen_reg, out_y_reg, out_x_reg};

    assign row_eff    = flags_reg[7] ? 4'(SPRITE_ROWS - 1) - row_reg : row_reg;
    assign kk         = flags_reg[6] ? 2'd3 - pix_reg[2:1] : pix_reg[2:1];
    assign nib_hi     = (pix_reg[0] == 1'b0) != flags_reg[6];
    assign nib        = nib_hi ? gfx_rdata[7:4] : gfx_rdata[3:0];
    assign bg_nib     = bgsel_reg ? bg_rdata[3:0] : bg_rdata[7:4];
    assign col        = {1'b0, sx_reg} + {6'd0, pix_reg};
    assign emit       = (nib != 4'd0) && !col[8];
    assign out_free   = !out_valid_reg || m_tready;
    assign emit_stall = emit && pend_valid_reg && !out_free;

    srbc_alu #(.W(ALU_W)) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    srbc_ram #(.WIDTH(8), .DEPTH(GRAPHICS_BYTES)) u_gfx_ram (
        .aclk  (aclk),
        .we    (gfx_we),
        .waddr (gfx_waddr),
        .wdata (data_reg),
        .re    (gfx_re),
        .raddr (gaddr_reg),
        .rdata (gfx_rdata)
    );

    srbc_ram #(.WIDTH(8), .DEPTH(2 ** BG_AW)) u_bg_ram (
        .aclk  (aclk),
        .we    (bg_we),
        .waddr (addr_reg[BG_AW-1:0]),
        .wdata (data_reg),
        .re    (bg_re),
        .raddr (bg_raddr),
        .rdata (bg_rdata)
    );

    always_comb begin
        unique case (paddr[3:2])
            REG_PALETTE_BANK: prdata = {30'd0, palette_bank_reg};
            REG_SPRITE_BANK:  prdata = {31'd0, sprite_bank_reg};
            REG_CLIP_MIN_Y:   prdata = {23'd0, clip_min_reg};
            REG_CLIP_MAX_Y:   prdata = {23'd0, clip_max_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_tuser)
                        OP_BG_WRITE:  state_next = ST_WR_BG;
                        OP_GFX_WRITE: state_next = ST_WR_GFX;
                        OP_DRAW_ROW:  state_next = ST_Y0;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR_BG:   state_next = ST_IDLE;
            ST_WR_GFX:  state_next = ST_IDLE;
            ST_Y0:      state_next = ST_Y1;
            ST_Y1:      state_next = ST_CK_VB;
            ST_CK_VB:   state_next = alu_borrow ? ST_IDLE : ST_CK_MIN;
            ST_CK_MIN:  state_next = alu_borrow ? ST_IDLE : ST_CK_MAX;
            ST_CK_MAX:  state_next = alu_borrow ? ST_IDLE : ST_B_IMG;
            ST_B_IMG:   state_next = ST_B_BANK;
            ST_B_BANK:  state_next = ST_B_ROW;
            ST_B_ROW:   state_next = ST_B_MOD;
            ST_B_MOD:   state_next = alu_borrow ? ST_BG_BASE : ST_B_MOD;
            ST_BG_BASE: state_next = ST_P_GA;
            ST_P_GA:    state_next = ST_P_GM;
            ST_P_GM:    state_next = ST_P_BA;
            ST_P_BA:    state_next = ST_P_EMIT;
            ST_P_EMIT: begin
                if (!emit_stall) begin
                    state_next = (pix_reg == 3'(ROW_PIXELS - 1)) ? ST_FLUSH : ST_P_GA;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and next values
    always_comb begin
        alu_op          = ALU_ADD;
        alu_a           = '0;
        alu_b           = '0;
        gfx_we          = 1'b0;
        gfx_re          = 1'b0;
        gfx_waddr       = GFX_AW'(addr_reg);
        bg_we           = 1'b0;
        bg_re           = 1'b0;
        bg_raddr        = '0;
        y_next          = y_reg;
        acc_next        = acc_reg;
        bgb_next        = bgb_reg;
        ga_next         = ga_reg;
        gaddr_next      = gaddr_reg;
        pix_next        = pix_reg;
        bgsel_next      = bgsel_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        pend_pen_next   = pend_pen_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_pen_next    = out_pen_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_WR_BG: begin
                bg_we = 1'b1;
            end
            ST_WR_GFX: begin
                alu_op    = ALU_SUB;
                alu_a     = ALU_W'(addr_reg);
                alu_b     = ALU_W'(GRAPHICS_BYTES);
                gfx_we    = 1'b1;
                gfx_waddr = alu_borrow ? alu_a[GFX_AW-1:0] : alu_res[GFX_AW-1:0];
            end
            ST_Y0: begin
                alu_a  = ALU_W'(sy_reg);
                alu_b  = ALU_W'(SPRITE_Y_OFFSET + VBLANK_END);
                y_next = alu_res[8:0];
            end
            ST_Y1: begin
                // row 0 keeps the unwrapped line
                alu_a  = ALU_W'(y_reg);
                alu_b  = ALU_W'(row_reg);
                y_next = (row_reg != 4'd0) ? {1'b0, alu_res[7:0]} : y_reg;
            end
            ST_CK_VB: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(y_reg);
                alu_b  = ALU_W'(LINE_MIN_OFFSET + VBLANK_END);
            end
            ST_CK_MIN: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(y_reg);
                alu_b  = ALU_W'(clip_min_reg);
            end
            ST_CK_MAX: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(clip_max_reg);
                alu_b  = ALU_W'(y_reg);
            end
            ST_B_IMG: begin
                alu_op   = ALU_SUB;
                alu_a    = ALU_W'({flags_reg[2:0], image_reg, 6'd0});
                alu_b    = ALU_W'(GRAPHICS_BYTES);
                acc_next = alu_borrow ? alu_a : alu_res;
            end
            ST_B_BANK: begin
                alu_a    = acc_reg;
                alu_b    = sprite_bank_reg ? ALU_W'(BANK_OFFSET) : '0;
                acc_next = alu_res;
            end
            ST_B_ROW: begin
                alu_a    = acc_reg;
                alu_b    = ALU_W'({row_eff, 2'd0});
                acc_next = alu_res;
            end
            ST_B_MOD: begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg;
                alu_b  = ALU_W'(GRAPHICS_BYTES);
                if (!alu_borrow) begin
                    acc_next = alu_res;
                end
            end
            ST_BG_BASE: begin
                alu_op   = ALU_SUB;
                alu_a    = ALU_W'(y_reg);
                alu_b    = ALU_W'(VBLANK_END);
                bgb_next = {alu_res[7:0], sx_reg};
                pix_next = '0;
            end
            ST_P_GA: begin
                alu_a   = acc_reg;
                alu_b   = ALU_W'(kk);
                ga_next = alu_res;
            end
            ST_P_GM: begin
                alu_op     = ALU_SUB;
                alu_a      = ga_reg;
                alu_b      = ALU_W'(GRAPHICS_BYTES);
                gaddr_next = alu_borrow ? ga_reg[GFX_AW-1:0] : alu_res[GFX_AW-1:0];
            end
            ST_P_BA: begin
                alu_a      = ALU_W'(bgb_reg);
                alu_b      = ALU_W'(pix_reg);
                gfx_re     = 1'b1;
                bg_re      = 1'b1;
                bg_raddr   = alu_res[15:1];
                bgsel_next = alu_res[0];
            end
            ST_P_EMIT: begin
                if (!emit_stall) begin
                    pix_next = pix_reg + 3'd1;
                    if (emit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_x_next     = pend_x_reg;
                            out_y_next     = pend_y_reg;
                            out_pen_next   = pend_pen_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_x_next     = col[7:0];
                        pend_y_next     = y_reg;
                        pend_pen_next   = {palette_bank_reg, nib, bg_nib};
                    end
                end
            end
            ST_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    out_valid_next  = 1'b1;
                    out_x_next      = pend_x_reg;
                    out_y_next      = pend_y_reg;
                    out_pen_next    = pend_pen_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            palette_bank_reg <= '0;
            sprite_bank_reg  <= 1'b0;
            clip_min_reg     <= 9'd0;
            clip_max_reg     <= 9'd511;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we) begin
                unique case (paddr[3:2])
                    REG_PALETTE_BANK: palette_bank_reg <= pwdata[1:0];
                    REG_SPRITE_BANK:  sprite_bank_reg  <= pwdata[0];
                    REG_CLIP_MIN_Y:   clip_min_reg     <= pwdata[8:0];
                    REG_CLIP_MAX_Y:   clip_max_reg     <= pwdata[8:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            addr_reg  <= s_tdata[16:0];
            data_reg  <= s_tdata[24:17];
            flags_reg <= s_tdata[32:25];
            image_reg <= s_tdata[40:33];
            sy_reg    <= s_tdata[48:41];
            sx_reg    <= s_tdata[56:49];
            row_reg   <= s_tdata[60:57];
        end
        y_reg        <= y_next;
        acc_reg      <= acc_next;
        bgb_reg      <= bgb_next;
        ga_reg       <= ga_next;
        gaddr_reg    <= gaddr_next;
        pix_reg      <= pix_next;
        bgsel_reg    <= bgsel_next;
        pend_x_reg   <= pend_x_next;
        pend_y_reg   <= pend_y_next;
        pend_pen_reg <= pend_pen_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_pen_reg  <= out_pen_next;
        out_last_reg <= out_last_next;
    end

endmodule

[rtl/srbc_checker.sv]
// Port-level assertions for the sprite row / background combiner, with bind.
module srbc_checker
    import srbc_pkg::*;
#(
    parameter int VBLANK_END = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    a_busy_after_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != OP_UNUSED) |=> !s_tready)
        else $error("ready right after a working item");

    a_line_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:8] >= 9'(LINE_MIN_OFFSET + VBLANK_END)))
        else $error("pixel drawn above the visible area");

endmodule

bind sprite_row_background_combine srbc_checker #(.VBLANK_END(VBLANK_END)) u_srbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[tb/tb_top.sv]
// Self-checking testbench for the sprite row / background combiner.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srbc_pkg::*;

    localparam int VBLANK_END     = 16;
    localparam int GRAPHICS_BYTES = 131072;
    localparam int BANK_OFFSET    = 65536;
    localparam int DRAIN_CYCLES   = 64;
    // watchdog limit; leaves room for a row plus stalls on either side
    localparam int STALL_LIMIT    = 4000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [16:0] address;
        logic [7:0]  data;
        logic [7:0]  flags;
        logic [7:0]  image;
        logic [7:0]  sy;
        logic [7:0]  sx;
        logic [3:0]  row;
    } sprite_cmd_t;

    typedef struct packed {
        logic [7:0] x;
        logic [8:0] y;
        logic [9:0] pen;
        logic       tail;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_BG_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sprite_row_background_combine #(
        .VBLANK_END    (VBLANK_END),
        .GRAPHICS_BYTES(GRAPHICS_BYTES),
        .BANK_OFFSET   (BANK_OFFSET)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 aclk = ~aclk;

    // register copies
    logic [1:0] palette_r   = 2'd0;
    logic       sprite_bank_r = 1'b0;
    logic [8:0] clip_min_r  = 9'd0;
    logic [8:0] clip_max_r  = 9'd511;

    // store copies, and what the stimulus has written so far
    logic [3:0] bg_mem  [0:65535];
    logic [7:0] gfx_mem [0:GRAPHICS_BYTES-1];
    bit         bg_known  [0:65535];
    bit         gfx_known [0:GRAPHICS_BYTES-1];

    sprite_cmd_t cmd_queue[$];
    sprite_cmd_t recent_draws[$];
    sprite_cmd_t held_cmd;
    pixel_t      pixels_due[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_draws = 0;
    int n_pixels = 0;
    int n_errors = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int quiet_cycles = 0;

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= 20) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic logic [8:0] row_line(sprite_cmd_t c);
        int y;
        y = c.sy + SPRITE_Y_OFFSET + VBLANK_END;
        if (c.row != 0) y = (y + c.row) & 255;
        return 9'(y);
    endfunction

    function automatic bit row_visible(logic [8:0] ln);
        return ln >= LINE_MIN_OFFSET + VBLANK_END && ln >= clip_min_r && ln <= clip_max_r;
    endfunction

    function automatic logic [16:0] row_base(sprite_cmd_t c);
        int r;
        int b;
        r = c.flags[7] ? SPRITE_ROWS - 1 - c.row : c.row;
        b = sprite_bank_r * BANK_OFFSET + 64 * {c.flags[2:0], c.image} + 4 * r;
        return 17'(b % GRAPHICS_BYTES);
    endfunction

    function automatic logic [15:0] bg_origin(sprite_cmd_t c, logic [8:0] ln);
        return 16'((int'(ln) - VBLANK_END) * 256 + c.sx);
    endfunction

    task automatic draw_row_pixels(sprite_cmd_t c);
        logic [8:0]  ln;
        logic [16:0] base;
        logic [15:0] bg;
        logic [7:0]  b;
        logic [3:0]  nib;
        pixel_t      px;
        bit          have;
        int          col;
        ln = row_line(c);
        have = 0;
        if (!row_visible(ln)) return;
        base = row_base(c);
        bg = bg_origin(c, ln);
        for (int i = 0; i < ROW_PIXELS; i++) begin
            col = c.sx + i;
            if (c.flags[6]) b = gfx_mem[17'(base + 3 - (i >> 1))];
            else b = gfx_mem[17'(base + (i >> 1))];
            nib = (((i & 1) == 0) != c.flags[6]) ? b[7:4] : b[3:0];
            if (nib == 0 || col > 255) continue;
            if (have) pixels_due.push_back(px);
            px.x = 8'(col);
            px.y = ln;
            px.pen = {palette_r, nib, bg_mem[16'(bg + i)]};
            px.tail = 1'b0;
            have = 1;
        end
        if (have) begin
            px.tail = 1'b1;
            pixels_due.push_back(px);
        end
    endtask

    task automatic apply_item(sprite_cmd_t c);
        n_accepted++;
        case (c.opcode)
            OP_BG_WRITE: begin
                bg_mem[{c.address[14:0], 1'b0}] = c.data[7:4];
                bg_mem[{c.address[14:0], 1'b1}] = c.data[3:0];
            end
            OP_GFX_WRITE: gfx_mem[c.address] = c.data;
            OP_DRAW_ROW: begin
                n_draws++;
                draw_row_pixels(c);
            end
            default: ;
        endcase
    endtask

    task automatic check_pixel(pixel_t got);
        pixel_t want;
        if (pixels_due.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel x=%0d y=%0d pen=%0d tlast=%0b",
                                      got.x, got.y, got.pen, got.tail));
            return;
        end
        want = pixels_due.pop_front();
        n_pixels++;
        if (got.x != want.x || got.y != want.y || got.pen != want.pen || got.tail != want.tail)
            report_mismatch($sformatf("pixel x=%0d y=%0d pen=%0d tlast=%0b, want %0d %0d %0d %0b",
                                      got.x, got.y, got.pen, got.tail,
                                      want.x, want.y, want.pen, want.tail));
    endtask

    // item source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) apply_item(held_cmd);
            if (!s_tvalid || s_tready) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    held_cmd = cmd_queue.pop_front();
                    s_tdata  <= {3'b000, held_cmd.row, held_cmd.sx, held_cmd.sy, held_cmd.image,
                                 held_cmd.flags, held_cmd.data, held_cmd.address};
                    s_tuser  <= held_cmd.opcode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // pixel sink
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_pixel({m_tdata[7:0], m_tdata[16:8], m_tdata[26:17], m_tlast});
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d pixels outstanding",
                         quiet_cycles, pixels_due.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PALETTE_BANK: palette_r     = val[1:0];
            REG_SPRITE_BANK:  sprite_bank_r = val[0];
            REG_CLIP_MIN_Y:   clip_min_r    = val[8:0];
            REG_CLIP_MAX_Y:   clip_max_r    = val[8:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int pal, int bank, int ymin, int ymax);
        write_reg(REG_PALETTE_BANK, pal);
        write_reg(REG_SPRITE_BANK, bank);
        write_reg(REG_CLIP_MIN_Y, ymin);
        write_reg(REG_CLIP_MAX_Y, ymax);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (cmd_queue.size() != 0 || s_tvalid || pixels_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic sprite_cmd_t random_cmd(logic [1:0] op);
        sprite_cmd_t c;
        c.opcode  = op;
        c.address = 17'($urandom);
        c.data    = 8'($urandom);
        c.flags   = 8'($urandom);
        c.image   = 8'($urandom);
        c.sy      = 8'($urandom);
        c.sx      = 8'($urandom);
        c.row     = 4'($urandom);
        return c;
    endfunction

    function automatic logic [3:0] rand_nibble();
        return ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15, 1));
    endfunction

    task automatic push_cmd(sprite_cmd_t c);
        cmd_queue.push_back(c);
        if (c.opcode != OP_UNUSED) n_queued++;
    endtask

    task automatic push_gfx(logic [16:0] a, logic [7:0] d);
        sprite_cmd_t c;
        c = random_cmd(OP_GFX_WRITE);
        c.address = a;
        c.data = d;
        gfx_known[a] = 1;
        push_cmd(c);
    endtask

    task automatic push_bg(logic [16:0] a, logic [7:0] d);
        sprite_cmd_t c;
        c = random_cmd(OP_BG_WRITE);
        c.address = a;
        c.data = d;
        bg_known[{a[14:0], 1'b0}] = 1;
        bg_known[{a[14:0], 1'b1}] = 1;
        push_cmd(c);
    endtask

    // loads the row's unwritten data, all graphics if blank, then the draw
    task automatic queue_draw(sprite_cmd_t c, bit blank);
        logic [8:0]  ln;
        logic [16:0] base;
        logic [16:0] ga;
        logic [15:0] bg;
        logic [15:0] e;
        ln = row_line(c);
        if (row_visible(ln)) begin
            base = row_base(c);
            for (int k = 0; k < 4; k++) begin
                ga = 17'(base + k);
                if (blank || !gfx_known[ga])
                    push_gfx(ga, blank ? 8'h00 : {rand_nibble(), rand_nibble()});
            end
            bg = bg_origin(c, ln);
            for (int i = 0; i < ROW_PIXELS; i++) begin
                e = 16'(bg + i);
                if (!bg_known[e]) push_bg({2'($urandom_range(3)), e[15:1]}, 8'($urandom));
            end
        end
        push_cmd(c);
    endtask

    function automatic sprite_cmd_t make_draw(logic [7:0] flags, logic [7:0] image,
                                              logic [7:0] sy, logic [7:0] sx, logic [3:0] row);
        sprite_cmd_t c;
        c = random_cmd(OP_DRAW_ROW);
        c.flags = flags;
        c.image = image;
        c.sy    = sy;
        c.sx    = sx;
        c.row   = row;
        return c;
    endfunction

    task automatic gen_random(int target);
        int start;
        int k;
        sprite_cmd_t c;
        start = n_queued;
        while (n_queued - start < target) begin
            k = $urandom_range(99);
            if (k < 45 || recent_draws.size() == 0) begin
                c = random_cmd(OP_DRAW_ROW);
                recent_draws.push_back(c);
                queue_draw(c, 0);
            end else if (k < 70) begin
                queue_draw(recent_draws[$urandom_range(recent_draws.size() - 1)], 0);
            end else if (k < 80) begin
                push_gfx(17'($urandom), 8'($urandom));
            end else if (k < 90) begin
                push_bg(17'($urandom), 8'($urandom));
            end else begin
                push_cmd(random_cmd(OP_UNUSED));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corner rows under reset register values
        push_bg(17'h1ffff, 8'ha5);
        push_gfx(17'h1ffff, 8'h5a);
        queue_draw(make_draw(8'h00, 8'h00, 8'd0, 8'd0, 4'd0), 0);
        // both flips, top image, row 0 below line 255, right edge overflow
        queue_draw(make_draw(8'hc7, 8'hff, 8'd255, 8'd255, 4'd0), 0);
        // wraps into the blanking lines
        queue_draw(make_draw(8'h80, 8'h01, 8'd222, 8'd17, 4'd1), 0);
        // fully transparent row
        queue_draw(make_draw(8'h40, 8'h02, 8'd40, 8'd8, 4'd15), 1);
        push_cmd(random_cmd(OP_UNUSED));
        wait_drained();

        set_regs(3, 1, 0, 511);
        src_idle_pct = 62;
        gen_random(18);
        wait_drained();

        set_regs(1, 0, 40, 200);
        src_idle_pct = 0;
        sink_stall_pct = 62;
        gen_random(18);
        wait_drained();

        set_regs(2, 1, 100, 300);
        src_idle_pct = 24;
        sink_stall_pct = 24;
        gen_random(18);
        wait_drained();

        // empty clip window: every row rejected
        set_regs(0, 0, 511, 0);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        gen_random(5);
        wait_drained();

        set_regs(3, 0, 0, 511);
        gen_random(14);
        wait_drained();

        $display("Covered %0d items, %0d row draws and %0d checked pixels", n_accepted, n_draws,
                 n_pixels);
        $display("over six register settings and four idle/stall patterns, %0d mismatches",
                 n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
